// ===== rtl/rsob_pkg.sv =====
`timescale 1ns / 1ps
package rsob_pkg;

  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;
  localparam int unsigned CH_ALPHA = 3;

  localparam int unsigned ADDR_W = 3;
  localparam logic REG_BLEND_ENABLE = 1'b0;

  localparam int unsigned QUOT_W     = 8;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = QUOT_W / DIV_STEPS;

  typedef logic [3:0][7:0] pix_t;

  typedef struct packed {
    pix_t       src;
    pix_t       dst;
    logic [7:0] oa;
    logic       blend;
  } alpha_t;

  // rem holds the partial remainder, lo the dividend bits not yet used
  // on top and the quotient bits shifted in from the bottom
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] lo;
  } dchan_t;

  typedef struct packed {
    dchan_t [2:0] ch;
    logic [7:0]   oa;
    pix_t         src;
    logic         blend;
  } div_t;

  function automatic dchan_t div_step(dchan_t c, logic [7:0] oa);
    logic [8:0] t;
    dchan_t     n;
    t = {c.rem, c.lo[7]};
    if (t >= {1'b0, oa}) begin
      n.rem = 8'(t - {1'b0, oa});
      n.lo  = {c.lo[6:0], 1'b1};
    end else begin
      n.rem = t[7:0];
      n.lo  = {c.lo[6:0], 1'b0};
    end
    return n;
  endfunction

endpackage

// ===== rtl/rgba_source_over_blend.sv =====
`timescale 1ns / 1ps
// channel  | signals                         | word
// ---------+---------------------------------+----------------------------------
// in       | in_valid / in_ready             | src_red..src_alpha, dst_red..dst_alpha
// out      | out_valid / out_ready           | out_red..out_green..out_alpha
// cfg      | psel penable pwrite paddr pwdata | blend_enable at 0x0
//
// One word per cycle sustained while out_ready stays high; the stages are
// two alpha stages, two multiply/sum stages, four radix-2 divider stages
// (two quotient bits each), one output register.
// rst clears every valid bit and sets blend_enable to 1.
// Each stage holds its word while the next one is full and stalled; bubbles
// close up, so in_ready stays high until all stages are occupied.
module rgba_source_over_blend (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsob_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  src_red,
  input  logic [7:0]                  src_green,
  input  logic [7:0]                  src_blue,
  input  logic [7:0]                  src_alpha,
  input  logic [7:0]                  dst_red,
  input  logic [7:0]                  dst_green,
  input  logic [7:0]                  dst_blue,
  input  logic [7:0]                  dst_alpha,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic [7:0]                  out_alpha
);
  import rsob_pkg::*;

  logic   blend_en;
  logic   cfg_wr;
  logic   cfg_idx;

  pix_t   src;
  pix_t   dst;

  logic   a_valid;
  logic   a_ready;
  alpha_t a_data;

  logic   dv [0:DIV_STAGES];
  logic   dr [0:DIV_STAGES];
  div_t   dd [0:DIV_STAGES];

  div_t   last;
  logic   last_valid;
  logic   out_en;
  pix_t   res;

  // config port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_en <= 1'b1;
    end else if (cfg_wr && cfg_idx == REG_BLEND_ENABLE) begin
      blend_en <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx == REG_BLEND_ENABLE) begin
      prdata[0] = blend_en;
    end
  end

  assign src[CH_RED]   = src_red;
  assign src[CH_GREEN] = src_green;
  assign src[CH_BLUE]  = src_blue;
  assign src[CH_ALPHA] = src_alpha;
  assign dst[CH_RED]   = dst_red;
  assign dst[CH_GREEN] = dst_green;
  assign dst[CH_BLUE]  = dst_blue;
  assign dst[CH_ALPHA] = dst_alpha;

  rsob_alpha u_alpha (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .src       (src),
    .dst       (dst),
    .blend     (blend_en),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .out       (a_data)
  );

  rsob_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in        (a_data),
    .out_valid (dv[0]),
    .out_ready (dr[0]),
    .out       (dd[0])
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    rsob_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[i]),
      .in_ready  (dr[i]),
      .in        (dd[i]),
      .out_valid (dv[i+1]),
      .out_ready (dr[i+1]),
      .out       (dd[i+1])
    );
  end

  assign last       = dd[DIV_STAGES];
  assign last_valid = dv[DIV_STAGES];
  assign out_en     = !out_valid || out_ready;
  assign dr[DIV_STAGES] = out_en;

  always_comb begin
    res = last.src;
    if (last.blend) begin
      res[CH_ALPHA] = last.oa;
      if (last.oa != '0) begin
        for (int k = 0; k < 3; k++) begin
          res[k] = last.ch[k].lo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && last_valid) begin
      out_red   <= res[CH_RED];
      out_green <= res[CH_GREEN];
      out_blue  <= res[CH_BLUE];
      out_alpha <= res[CH_ALPHA];
    end
  end

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (last_valid && last.blend && last.oa != 8'd0) |->
      (last.ch[0].rem < last.oa && last.ch[1].rem < last.oa &&
       last.ch[2].rem < last.oa))
    else $error("divider remainder not below output alpha");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_valid) |=> !out_valid)
    else $error("output word repeated after drain");

  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    !cfg_wr |=> $stable(blend_en))
    else $error("blend enable changed without a write");

endmodule

// ===== rtl/rsob_alpha.sv =====
`timescale 1ns / 1ps
module rsob_alpha (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rsob_pkg::pix_t    src,
  input  rsob_pkg::pix_t    dst,
  input  logic              blend,
  output logic              out_valid,
  input  logic              out_ready,
  output rsob_pkg::alpha_t  out
);
  import rsob_pkg::*;

  logic        va;
  logic        ready_a;
  pix_t        src_a;
  pix_t        dst_a;
  logic        blend_a;
  logic [15:0] prod_a;

  logic        vb;
  logic        ready_b;
  alpha_t      data_b;

  logic [7:0]  quo;
  logic [7:0]  oa_next;

  assign ready_b  = !vb || out_ready;
  assign ready_a  = !va || ready_b;
  assign in_ready = ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ready_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      src_a   <= src;
      dst_a   <= dst;
      blend_a <= blend;
      prod_a  <= src[CH_ALPHA] * dst[CH_ALPHA];
    end
  end

  // floor(p/255) for p up to 255*255
  assign quo     = 8'((17'(prod_a) + 17'(prod_a[15:8]) + 17'd1) >> 8);
  assign oa_next = src_a[CH_ALPHA] + dst_a[CH_ALPHA] - quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (ready_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && va) begin
      data_b.src   <= src_a;
      data_b.dst   <= dst_a;
      data_b.oa    <= oa_next;
      data_b.blend <= blend_a;
    end
  end

  assign out_valid = vb;
  assign out       = data_b;

endmodule

// ===== rtl/rsob_mix.sv =====
`timescale 1ns / 1ps
module rsob_mix (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rsob_pkg::alpha_t  in,
  output logic              out_valid,
  input  logic              out_ready,
  output rsob_pkg::div_t    out
);
  import rsob_pkg::*;

  logic              vc;
  logic              ready_c;
  logic [2:0][15:0]  ps_c;
  logic [2:0][15:0]  pd_c;
  logic [7:0]        oa_c;
  pix_t              src_c;
  logic              blend_c;
  logic [7:0]        wd;

  logic              vd;
  logic              ready_d;
  div_t              data_d;
  logic [2:0][15:0]  num;

  assign ready_d  = !vd || out_ready;
  assign ready_c  = !vc || ready_d;
  assign in_ready = ready_c;

  // oa >= sa whenever blending is on
  assign wd = in.oa - in.src[CH_ALPHA];

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (ready_c) begin
      vc <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c && in_valid) begin
      for (int k = 0; k < 3; k++) begin
        ps_c[k] <= in.src[k] * in.src[CH_ALPHA];
        pd_c[k] <= in.dst[k] * wd;
      end
      oa_c    <= in.oa;
      src_c   <= in.src;
      blend_c <= in.blend;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = ps_c[k] + pd_c[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (ready_d) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_d && vc) begin
      for (int k = 0; k < 3; k++) begin
        data_d.ch[k].rem <= num[k][15:8];
        data_d.ch[k].lo  <= num[k][7:0];
      end
      data_d.oa    <= oa_c;
      data_d.src   <= src_c;
      data_d.blend <= blend_c;
    end
  end

  assign out_valid = vd;
  assign out       = data_d;

endmodule

// ===== rtl/rsob_div_stage.sv =====
`timescale 1ns / 1ps
module rsob_div_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rsob_pkg::div_t  in,
  output logic            out_valid,
  input  logic            out_ready,
  output rsob_pkg::div_t  out
);
  import rsob_pkg::*;

  logic v;
  div_t data;
  div_t data_next;

  assign in_ready = !v || out_ready;

  always_comb begin
    data_next = in;
    for (int k = 0; k < 3; k++) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        data_next.ch[k] = div_step(data_next.ch[k], in.oa);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = v;
  assign out       = data;

endmodule
